// File: src/lpd_pkg.sv
// lpd_pkg: request kinds, flow codes, register indexes and the queue entry and result
// records shared by the deframer front, back and top level
// no dependencies
`default_nettype none

package lpd_pkg;

   // request kinds as carried in req_tuser
   typedef enum logic [1:0] {
      REQ_RX_BYTE    = 2'd0,
      REQ_RELEASE    = 2'd1,
      REQ_MAN_REFUSE = 2'd2,
      REQ_MAN_ACCEPT = 2'd3
   } req_kind_type;

   // flow control action reported with each result
   typedef enum logic [1:0] {
      FLOW_NONE   = 2'd0,
      FLOW_REFUSE = 2'd1,
      FLOW_ACCEPT = 2'd2
   } flow_action_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_REFUSE_THRESHOLD = 2'd0,
      CSR_ACCEPT_THRESHOLD = 2'd1,
      CSR_OVERRIDE_KEY     = 2'd2
   } csr_index_type;

   localparam logic [31:0] HDR_BYTES    = 32'd4;
   localparam logic [1:0]  HDR_LAST     = 2'd3;
   localparam logic [31:0] RESET_REFUSE = 32'd20480;
   localparam logic [31:0] RESET_ACCEPT = 32'd10240;

   // queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 80;

   // classified request held in the queue
   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   rx_byte;
      logic         seg_first;
      logic [31:0]  release_amt;   // release length plus header bytes
      logic [7:0]   key;
   } cmd_type;

   // head of the queue as seen by the back part
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // one result record
   typedef struct packed {
      logic            byte_valid;
      logic [7:0]      payload_byte;
      logic            msg_last;
      logic            msg_empty;
      logic [31:0]     msg_length;
      flow_action_type flow_action;
      logic            request_ok;
      logic [31:0]     buffered_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/lpd_front.sv
// lpd_front: accepts requests, classifies them and holds them in a short queue
// depends on lpd_pkg
`default_nettype none

module lpd_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // rx_byte[7:0], seg_first[8], release_len[40:9], key[48:41], zero pad
   input  wire  [lpd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[1:0]
   input  wire  [1:0]                          req_tuser,
   output lpd_pkg::qhead_type                  head,
   input  wire                                 pop
);

   lpd_pkg::cmd_type                   queue_mem [lpd_pkg::QUEUE_DEPTH];
   logic [lpd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lpd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lpd_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   lpd_pkg::cmd_type                   cmd;
   logic                               push;

   // classify the request, unused fields cleared
   always_comb begin
      cmd             = '0;
      cmd.kind        = lpd_pkg::req_kind_type'(req_tuser);
      unique case (cmd.kind)
         lpd_pkg::REQ_RX_BYTE: begin
            cmd.rx_byte   = req_tdata[7:0];
            cmd.seg_first = req_tdata[8];
         end
         lpd_pkg::REQ_RELEASE: begin
            cmd.release_amt = req_tdata[40:9] + lpd_pkg::HDR_BYTES;
         end
         lpd_pkg::REQ_MAN_REFUSE, lpd_pkg::REQ_MAN_ACCEPT: begin
            cmd.key = req_tdata[48:41];
         end
         default: begin
            cmd.rx_byte = '0;
         end
      endcase
   end

   assign req_tready = (count_ff != lpd_pkg::QUEUE_CNT_W'(lpd_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   assign head.valid = (count_ff != '0);
   assign head.cmd   = queue_mem[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpd_pkg::QUEUE_CNT_W'(lpd_pkg::QUEUE_DEPTH))
      else $error("queue fill beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: src/lpd_back.sv
// lpd_back: header parsing, payload counting, buffered count and flow decisions,
// configuration registers and the result register
// depends on lpd_pkg
`default_nettype none

module lpd_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [1:0]                          csr_index,
   input  wire  [31:0]                         csr_wdata,
   input  lpd_pkg::qhead_type                  head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // payload_byte[7:0], msg_length[39:8], flow_action[41:40], request_ok[42],
   // buffered_count[74:43], zero pad
   output logic [lpd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // byte_valid[0], msg_empty[1]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   logic [31:0]        refuse_ff;
   logic [31:0]        accept_ff;
   logic [7:0]         ovk_ff;

   logic               in_payload_ff, in_payload_in;
   logic [1:0]         header_count_ff, header_count_in;
   logic [31:0]        length_accum_ff, length_accum_in;
   logic [31:0]        bytes_left_ff, bytes_left_in;
   logic [31:0]        buffered_ff, buffered_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lpd_pkg::rsp_type   rsp_ff, rsp_in;

   logic [31:0]        buf_release;
   logic [31:0]        new_accum;
   logic               ovk_zero;
   logic               refuse_level;
   logic               accept_level;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         refuse_ff <= lpd_pkg::RESET_REFUSE;
         accept_ff <= lpd_pkg::RESET_ACCEPT;
         ovk_ff    <= '0;
      end else if (csr_we) begin
         unique case (lpd_pkg::csr_index_type'(csr_index))
            lpd_pkg::CSR_REFUSE_THRESHOLD: refuse_ff <= csr_wdata;
            lpd_pkg::CSR_ACCEPT_THRESHOLD: accept_ff <= csr_wdata;
            lpd_pkg::CSR_OVERRIDE_KEY:     ovk_ff    <= csr_wdata[7:0];
            default:                       ovk_ff    <= ovk_ff;
         endcase
      end
   end

   // take the queue head whenever the result register is free or draining
   assign pop = head.valid && (!rsp_valid_ff || rsp_tready);

   // threshold tests on the current count
   assign ovk_zero     = (ovk_ff == '0);
   assign refuse_level = (refuse_ff == '0) || (buffered_ff >= refuse_ff);
   assign accept_level = (accept_ff == '0) || (buffered_ff <= accept_ff);
   assign buf_release  = buffered_ff - head.cmd.release_amt;

   // header byte merged into the little-endian length
   always_comb begin
      if (header_count_ff == 2'd0) begin
         new_accum = {24'd0, head.cmd.rx_byte};
      end else begin
         new_accum = length_accum_ff
                   | ({24'd0, head.cmd.rx_byte} << {header_count_ff, 3'b000});
      end
   end

   // request execution
   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      length_accum_in = length_accum_ff;
      bytes_left_in   = bytes_left_ff;
      buffered_in     = buffered_ff;
      rsp_in          = '0;

      unique case (head.cmd.kind)
         lpd_pkg::REQ_RX_BYTE: begin
            // automatic refuse at segment start
            if (head.cmd.seg_first && (refuse_ff != '0) && (buffered_ff >= refuse_ff)
                && ovk_zero) begin
               rsp_in.flow_action = lpd_pkg::FLOW_REFUSE;
               rsp_in.request_ok  = 1'b1;
            end
            buffered_in = buffered_ff + 32'd1;
            if (!in_payload_ff) begin
               length_accum_in = new_accum;
               if (header_count_ff == lpd_pkg::HDR_LAST) begin
                  header_count_in = 2'd0;
                  if (new_accum == '0) begin
                     rsp_in.msg_empty = 1'b1;
                     rsp_in.msg_last  = 1'b1;
                  end else begin
                     in_payload_in     = 1'b1;
                     bytes_left_in     = new_accum;
                     rsp_in.msg_length = new_accum;
                  end
               end else begin
                  header_count_in = header_count_ff + 2'd1;
               end
            end else begin
               rsp_in.byte_valid   = 1'b1;
               rsp_in.payload_byte = head.cmd.rx_byte;
               rsp_in.msg_length   = length_accum_ff;
               bytes_left_in       = bytes_left_ff - 32'd1;
               if (bytes_left_ff == 32'd1) begin
                  rsp_in.msg_last = 1'b1;
                  in_payload_in   = 1'b0;
                  header_count_in = 2'd0;
               end
            end
         end
         lpd_pkg::REQ_RELEASE: begin
            // automatic accept once the count has fallen far enough
            buffered_in = buf_release;
            if ((accept_ff != '0) && (buf_release <= accept_ff) && ovk_zero) begin
               rsp_in.flow_action = lpd_pkg::FLOW_ACCEPT;
               rsp_in.request_ok  = 1'b1;
            end
         end
         lpd_pkg::REQ_MAN_REFUSE: begin
            if (ovk_zero ? refuse_level : (ovk_ff == head.cmd.key)) begin
               rsp_in.flow_action = lpd_pkg::FLOW_REFUSE;
               rsp_in.request_ok  = 1'b1;
            end
         end
         lpd_pkg::REQ_MAN_ACCEPT: begin
            if (ovk_zero ? accept_level : (ovk_ff == head.cmd.key)) begin
               rsp_in.flow_action = lpd_pkg::FLOW_ACCEPT;
               rsp_in.request_ok  = 1'b1;
            end
         end
         default: begin
            rsp_in.request_ok = 1'b0;
         end
      endcase
      rsp_in.buffered_count = buffered_in;
   end

   // result valid flag
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // deframer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= '0;
         length_accum_ff <= '0;
         bytes_left_ff   <= '0;
         buffered_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            in_payload_ff   <= in_payload_in;
            header_count_ff <= header_count_in;
            length_accum_ff <= length_accum_in;
            bytes_left_ff   <= bytes_left_in;
            buffered_ff     <= buffered_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.msg_last;
   assign rsp_tuser  = {rsp_ff.msg_empty, rsp_ff.byte_valid};
   assign rsp_tdata  = {5'd0, rsp_ff.buffered_count, rsp_ff.request_ok,
                        rsp_ff.flow_action, rsp_ff.msg_length, rsp_ff.payload_byte};

`ifndef SYNTHESIS
   a_rx_counts: assert property (@(posedge clock) disable iff (reset)
      pop && (head.cmd.kind == lpd_pkg::REQ_RX_BYTE)
      |=> buffered_ff == $past(buffered_ff) + 32'd1)
      else $error("received byte not counted");
   a_payload_header: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> header_count_ff == 2'd0)
      else $error("header count live during payload");
   a_ok_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.request_ok == (rsp_ff.flow_action != lpd_pkg::FLOW_NONE)))
      else $error("request_ok and flow_action disagree");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: src/length_prefixed_deframer_flow_ctrl_core.sv
// length_prefixed_deframer_flow_ctrl_core: top level of the length-prefixed deframer
// with receive flow control; instantiates lpd_front and lpd_back, uses lpd_pkg
//
//   channel  dir  handshake              contents
//   req      in   req_tvalid/tready      tuser kind, tdata byte/seg/length/key
//   rsp      out  rsp_tvalid/tready      tdata byte/length/flow/count, tuser, tlast
//   csr      in   csr_we                 index 0..2, 32-bit write data
//
// one request per clock while results are taken; a request passes through a queue slot,
// then the result register, before its result is valid; the back updates its deframer
// state as it pops the queue head
// synchronous active-high reset; no clearing pass, the block accepts right after reset
// the two-entry queue absorbs a stall on the result side before req_tready drops
`default_nettype none

module length_prefixed_deframer_flow_ctrl_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // rx_byte[7:0], seg_first[8], release_len[40:9], key[48:41], zero pad
   input  wire  [lpd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[1:0]
   input  wire  [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // payload_byte[7:0], msg_length[39:8], flow_action[41:40], request_ok[42],
   // buffered_count[74:43], zero pad
   output logic [lpd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // byte_valid[0], msg_empty[1]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  wire                                 csr_we,
   input  wire  [1:0]                          csr_index,
   input  wire  [31:0]                         csr_wdata
);

   lpd_pkg::qhead_type head;
   logic               pop;

   // request intake and queue
   lpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   // execution and results
   lpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: test/tb.sv
// tb: self-checking bench for length_prefixed_deframer_flow_ctrl_core, drives framed byte
// traffic, releases and manual flow requests and checks every result against a predictor
// depends on lpd_pkg and the core
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // deframer and flow control predictor with the store of expected results
   class lpd_scoreboard;
      logic [31:0]      refuse_level;
      logic [31:0]      accept_level;
      logic [7:0]       override_key;
      logic             in_payload;
      logic [1:0]       header_count;
      logic [31:0]      length_accum;
      logic [31:0]      bytes_left;
      logic [31:0]      buffered;
      lpd_pkg::rsp_type expected_rsp[$];
      int unsigned      mismatches;

      function new();
         refuse_level = lpd_pkg::RESET_REFUSE;
         accept_level = lpd_pkg::RESET_ACCEPT;
         override_key = '0;
         in_payload   = 1'b0;
         header_count = '0;
         length_accum = '0;
         bytes_left   = '0;
         buffered     = '0;
         mismatches   = 0;
      endfunction

      function void set_register(lpd_pkg::csr_index_type idx, logic [31:0] value);
         case (idx)
            lpd_pkg::CSR_REFUSE_THRESHOLD: refuse_level = value;
            lpd_pkg::CSR_ACCEPT_THRESHOLD: accept_level = value;
            lpd_pkg::CSR_OVERRIDE_KEY:     override_key = value[7:0];
            default: ;
         endcase
      endfunction

      function logic refuse_granted(logic [7:0] key);
         if (override_key != 0) return override_key == key;
         if (refuse_level != 0) return buffered >= refuse_level;
         return 1'b1;
      endfunction

      function logic accept_granted(logic [7:0] key);
         if (override_key != 0) return override_key == key;
         if (accept_level != 0) return buffered <= accept_level;
         return 1'b1;
      endfunction

      // advance the state by one accepted request and queue its result
      function void note_request(lpd_pkg::req_kind_type kind, logic [7:0] rx, logic seg,
                                 logic [31:0] rel_len, logic [7:0] key);
         lpd_pkg::rsp_type r;
         r = '0;
         case (kind)
            lpd_pkg::REQ_RX_BYTE: begin
               // automatic refuse at a segment start, judged before the byte counts
               if (seg && refuse_level != 0 && buffered >= refuse_level &&
                   refuse_granted(8'd0)) begin
                  r.flow_action = lpd_pkg::FLOW_REFUSE;
                  r.request_ok  = 1'b1;
               end
               buffered = buffered + 32'd1;
               if (!in_payload) begin
                  if (header_count == 0) length_accum = {24'd0, rx};
                  else length_accum = length_accum | ({24'd0, rx} << (8 * header_count));
                  if (header_count == lpd_pkg::HDR_LAST) begin
                     header_count = '0;
                     if (length_accum == 0) begin
                        r.msg_empty = 1'b1;
                        r.msg_last  = 1'b1;
                     end else begin
                        in_payload   = 1'b1;
                        bytes_left   = length_accum;
                        r.msg_length = length_accum;
                     end
                  end else begin
                     header_count = header_count + 2'd1;
                  end
               end else begin
                  r.byte_valid   = 1'b1;
                  r.payload_byte = rx;
                  r.msg_length   = length_accum;
                  bytes_left     = bytes_left - 32'd1;
                  if (bytes_left == 0) begin
                     r.msg_last   = 1'b1;
                     in_payload   = 1'b0;
                     header_count = '0;
                  end
               end
            end
            lpd_pkg::REQ_RELEASE: begin
               buffered = buffered - (rel_len + lpd_pkg::HDR_BYTES);
               if (accept_level != 0 && buffered <= accept_level && accept_granted(8'd0)) begin
                  r.flow_action = lpd_pkg::FLOW_ACCEPT;
                  r.request_ok  = 1'b1;
               end
            end
            lpd_pkg::REQ_MAN_REFUSE: begin
               if (refuse_granted(key)) begin
                  r.flow_action = lpd_pkg::FLOW_REFUSE;
                  r.request_ok  = 1'b1;
               end
            end
            default: begin
               if (accept_granted(key)) begin
                  r.flow_action = lpd_pkg::FLOW_ACCEPT;
                  r.request_ok  = 1'b1;
               end
            end
         endcase
         r.buffered_count = buffered;
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
         if (exp_val !== got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatches++;
         end
      endfunction

      // compare one result with the oldest expectation
      function void check_response(logic [lpd_pkg::RSP_DATA_W-1:0] data, logic [1:0] user,
                                   logic last);
         lpd_pkg::rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("result with no request waiting: tdata %0h", data);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         compare_field("byte_valid", 32'(e.byte_valid), 32'(user[0]));
         compare_field("payload_byte", 32'(e.payload_byte), 32'(data[7:0]));
         compare_field("msg_last", 32'(e.msg_last), 32'(last));
         compare_field("msg_empty", 32'(e.msg_empty), 32'(user[1]));
         compare_field("msg_length", e.msg_length, data[39:8]);
         compare_field("flow_action", 32'(e.flow_action), 32'(data[41:40]));
         compare_field("request_ok", 32'(e.request_ok), 32'(data[42]));
         compare_field("buffered_count", e.buffered_count, data[74:43]);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [lpd_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lpd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we;
   logic [1:0]                     csr_index;
   logic [31:0]                    csr_wdata;

   lpd_scoreboard sb;
   int unsigned   send_idle_pct;
   int unsigned   recv_idle_pct;
   logic [7:0]    active_key;
   logic [7:0]    frame_bytes[$];

   length_prefixed_deframer_flow_ctrl_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check accepted results, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   // one request: optional idle gap, then hold until accepted
   task automatic send_request(lpd_pkg::req_kind_type kind, logic [7:0] rx, logic seg,
                               logic [31:0] rel_len, logic [7:0] key);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, key, rel_len, seg, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, rx, seg, rel_len, key);
   endtask

   // stop sending and let every expected result come out
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all three registers back to back while idle
   task automatic write_registers(logic [31:0] refuse_val, logic [31:0] accept_val,
                                  logic [7:0] key_val);
      csr_we    <= 1'b1;
      csr_index <= lpd_pkg::CSR_REFUSE_THRESHOLD;
      csr_wdata <= refuse_val;
      @(posedge clock);
      sb.set_register(lpd_pkg::CSR_REFUSE_THRESHOLD, refuse_val);
      csr_index <= lpd_pkg::CSR_ACCEPT_THRESHOLD;
      csr_wdata <= accept_val;
      @(posedge clock);
      sb.set_register(lpd_pkg::CSR_ACCEPT_THRESHOLD, accept_val);
      csr_index <= lpd_pkg::CSR_OVERRIDE_KEY;
      csr_wdata <= {24'd0, key_val};
      @(posedge clock);
      sb.set_register(lpd_pkg::CSR_OVERRIDE_KEY, {24'd0, key_val});
      csr_we <= 1'b0;
      active_key = key_val;
   endtask

   // mostly well framed messages with releases and manual requests mixed in
   task automatic run_random_traffic(int unsigned count);
      int unsigned i;
      int unsigned j;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  k;
      logic [31:0] rel;
      for (i = 0; i < count; i++) begin
         // start a new message when the previous one is fully sent
         if (frame_bytes.size() == 0 && $urandom_range(99) < 70) begin
            pick = $urandom_range(99);
            if (pick < 10) len = 0;
            else if (pick < 90) len = $urandom_range(1, 12);
            else len = $urandom_range(13, 300);
            for (j = 0; j < 4; j++) frame_bytes.push_back(len[8*j +: 8]);
            for (j = 0; j < len; j++) frame_bytes.push_back(8'($urandom));
         end
         k = $urandom_range(1) ? active_key : 8'($urandom);
         if (frame_bytes.size() != 0 && $urandom_range(99) < 75) begin
            send_request(lpd_pkg::REQ_RX_BYTE, frame_bytes.pop_front(),
                         $urandom_range(99) < 25, $urandom, 8'($urandom));
         end else begin
            case ($urandom_range(3))
               0, 1: begin
                  pick = $urandom_range(99);
                  // random length wraps the count, rebalance pulls it back near zero
                  if (pick < 10) rel = $urandom;
                  else if (pick < 40) rel = sb.buffered - lpd_pkg::HDR_BYTES
                                            - $urandom_range(0, 64);
                  else rel = $urandom_range(0, 16);
                  send_request(lpd_pkg::REQ_RELEASE, 8'($urandom), 1'($urandom), rel,
                               8'($urandom));
               end
               2: send_request(lpd_pkg::REQ_MAN_REFUSE, 8'($urandom), 1'($urandom),
                               $urandom, k);
               default: send_request(lpd_pkg::REQ_MAN_ACCEPT, 8'($urandom), 1'($urandom),
                                     $urandom, k);
            endcase
         end
      end
   endtask

   initial begin
      int unsigned p;
      int unsigned i;
      logic [31:0] rt;
      logic [31:0] at;
      logic [7:0]  ok_key;
      logic [31:0] big_len;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = lpd_pkg::REQ_RX_BYTE;
      csr_we        = 1'b0;
      csr_index     = lpd_pkg::CSR_REFUSE_THRESHOLD;
      csr_wdata     = '0;
      send_idle_pct = 21;
      recv_idle_pct = 71;
      active_key    = '0;
      sb            = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero length header gives one empty message
      repeat (4) send_request(lpd_pkg::REQ_RX_BYTE, 8'h00, 1'b0, '0, '0);
      // three byte message carrying the byte extremes
      send_request(lpd_pkg::REQ_RX_BYTE, 8'h03, 1'b0, '0, '0);
      repeat (3) send_request(lpd_pkg::REQ_RX_BYTE, 8'h00, 1'b0, '0, '0);
      send_request(lpd_pkg::REQ_RX_BYTE, 8'h00, 1'b0, '0, '0);
      send_request(lpd_pkg::REQ_RX_BYTE, 8'hFF, 1'b0, '0, '0);
      send_request(lpd_pkg::REQ_RX_BYTE, 8'hA5, 1'b0, '0, '0);
      // release drops the count under the accept level: automatic accept
      send_request(lpd_pkg::REQ_RELEASE, '0, 1'b0, 32'd3, '0);
      // manual refuse below the refuse level fails, manual accept succeeds
      send_request(lpd_pkg::REQ_MAN_REFUSE, '0, 1'b0, '0, 8'h5A);
      send_request(lpd_pkg::REQ_MAN_ACCEPT, '0, 1'b0, '0, 8'hFF);
      // all-ones release length, then a release that wraps the count below zero
      send_request(lpd_pkg::REQ_RELEASE, '0, 1'b0, 32'hFFFF_FFFF, '0);
      send_request(lpd_pkg::REQ_RELEASE, '0, 1'b0, 32'd10, '0);
      // segment starts above the refuse level: automatic refuse
      send_request(lpd_pkg::REQ_RX_BYTE, 8'h01, 1'b1, '0, '0);
      repeat (3) send_request(lpd_pkg::REQ_RX_BYTE, 8'h00, 1'b0, '0, '0);
      send_request(lpd_pkg::REQ_RX_BYTE, 8'h7E, 1'b1, '0, '0);
      // manual refuse above the level
      send_request(lpd_pkg::REQ_MAN_REFUSE, '0, 1'b0, '0, 8'h00);
      wait_for_results();

      // random phases, each under its own register setting
      for (p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 21 : (p < 4) ? 71 : 0;
         recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 21 : 0;
         case (p)
            0: begin rt = 32'd48;         at = 32'd24;         ok_key = 8'h00; end
            1: begin rt = 32'd0;          at = 32'd0;          ok_key = 8'h00; end
            2: begin rt = 32'hFFFF_FFFF;  at = 32'hFFFF_FFFF;  ok_key = 8'h00; end
            3: begin rt = 32'd30;         at = 32'd10;         ok_key = 8'hFF; end
            4: begin
               rt     = $urandom_range(1, 64);
               at     = $urandom_range(1, 64);
               ok_key = 8'($urandom_range(1, 255));
            end
            default: begin rt = 32'd1; at = 32'd1; ok_key = 8'h01; end
         endcase
         write_registers(rt, at, ok_key);
         run_random_traffic(250);
         wait_for_results();
      end

      // finish the open message, then a header with the upper length bytes set
      while (frame_bytes.size() != 0)
         send_request(lpd_pkg::REQ_RX_BYTE, frame_bytes.pop_front(), 1'b0, '0, '0);
      big_len = {8'hFF, 8'hFF, 8'($urandom), 8'($urandom)};
      for (i = 0; i < 4; i++)
         send_request(lpd_pkg::REQ_RX_BYTE, big_len[8*i +: 8], 1'b1, '0, '0);
      repeat (20) send_request(lpd_pkg::REQ_RX_BYTE, 8'($urandom), 1'($urandom), '0, '0);
      wait_for_results();

      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit well beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
src/lpd_pkg.sv
src/lpd_front.sv
src/lpd_back.sv
src/length_prefixed_deframer_flow_ctrl_core.sv
test/tb.sv
